### rtl/core/whf_pkg.sv
// Shared constants, codes and types of the weighted histogram fill unit.
`timescale 1ns / 1ps

package whf_pkg;

   localparam int MAX_BINS   = 256;
   localparam int BIN_AW     = $clog2(MAX_BINS);
   localparam int CNT_W      = 9;

   localparam int SAMPLE_W   = 24;
   localparam int WEIGHT_W   = 16;
   localparam int SCALE_W    = 24;
   localparam int BINF_W     = 8;
   localparam int WSUM_W     = 40;
   localparam int SSUM_W     = 54;
   localparam int HITS_W     = 24;
   localparam int SQUARE_W   = 31;
   localparam int PROD_W     = 2 * SCALE_W;
   localparam int ENTRY_W    = WSUM_W + SSUM_W + HITS_W;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_X_MIN     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_X_MAX     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BIN_SCALE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_BIN_COUNT = CSR_IDX_W'(3);

   localparam logic KIND_FILL = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [HITS_W-1:0] HITS_FULL = {HITS_W{1'b1}};

   typedef enum logic [1:0] {
      STATUS_FILLED    = 2'd0,
      STATUS_OUT_RANGE = 2'd1,
      STATUS_READ_DATA = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

endpackage

### rtl/core/whf_if.sv
// Valid/ready channel interfaces of the weighted histogram fill unit.
`timescale 1ns / 1ps

interface whf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [whf_pkg::SAMPLE_W-1:0] sample;
   logic signed [whf_pkg::WEIGHT_W-1:0] weight;
   logic        [whf_pkg::BINF_W-1:0]   read_bin;

   modport source (output valid, kind, sample, weight, read_bin, input ready);
   modport sink   (input valid, kind, sample, weight, read_bin, output ready);
endinterface

interface whf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic [whf_pkg::BINF_W-1:0]        bin;
   logic signed [whf_pkg::WSUM_W-1:0] weight_sum;
   logic [whf_pkg::SSUM_W-1:0]        square_sum;
   logic [whf_pkg::HITS_W-1:0]        hit_count;

   modport source (output valid, status, bin, weight_sum, square_sum, hit_count,
                   input ready);
   modport sink   (input valid, status, bin, weight_sum, square_sum, hit_count,
                   output ready);
endinterface

interface whf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [whf_pkg::CSR_IDX_W-1:0]     index;
   logic [whf_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/weighted_histogram_fill_unit.sv
// Weighted histogram fill unit: range check, bin select and bin update.
//
// Channels: req_bus takes items, either a fill (sample, weight) or a read of
// one bin (read_bin). rsp_bus returns exactly one item per request: status,
// bin index and, for reads, the bin's weight sum, square sum and hit count.
// csr_bus writes x_min, x_max, bin_scale and bin_count; it is always ready
// and should be written only while no item is in flight.
// The response is registered when the update step finishes. A new request
// is taken only when the sequencer is idle. The sequencer walks input offset,
// multiply, index clamp with bin memory read, and read-modify-write; the
// single-port-pair bin memory is touched once per item.
// A stalled response is held in the output register; the next request is
// taken meanwhile and waits at the update step until the response leaves.
// Reset (synchronous, active high) restores the register defaults and clears
// the per-bin valid bits at once, so every bin reads as zero afterwards.
// A bin whose hit count is full stays frozen and reports saturation.
`timescale 1ns / 1ps

module weighted_histogram_fill_unit (
   input  logic        clock,
   input  logic        reset,
   whf_req_if.sink     req_bus,
   whf_rsp_if.source   rsp_bus,
   whf_csr_if.sink     csr_bus
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_IDX  = 4'b0100,
      ST_MOD  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [whf_pkg::SAMPLE_W-1:0] x_min_ff, x_max_ff;
   logic [whf_pkg::SCALE_W-1:0]         scale_ff;
   logic [whf_pkg::CNT_W-1:0]           bin_count_ff;

   // item in flight
   logic                                kind_ff;
   logic                                oor_ff, oor_in;
   logic [whf_pkg::SAMPLE_W-1:0]        offset_ff, offset_in;
   logic signed [whf_pkg::WEIGHT_W-1:0] weight_ff;
   logic [whf_pkg::BINF_W-1:0]          read_bin_ff;
   logic [whf_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic [whf_pkg::SQUARE_W-1:0]        square_ff, square_in;
   logic [whf_pkg::BIN_AW-1:0]          idx_ff, idx_in;

   logic [whf_pkg::MAX_BINS-1:0]        valid_ff;

   // response register
   logic                                rsp_valid_ff;
   whf_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic [whf_pkg::BINF_W-1:0]          rsp_bin_ff, rsp_bin_in;
   logic signed [whf_pkg::WSUM_W-1:0]   rsp_wsum_ff, rsp_wsum_in;
   logic [whf_pkg::SSUM_W-1:0]          rsp_ssum_ff, rsp_ssum_in;
   logic [whf_pkg::HITS_W-1:0]          rsp_hits_ff, rsp_hits_in;

   logic                                req_take;
   logic                                out_free;
   logic                                finish;

   logic signed [whf_pkg::SAMPLE_W:0]   diff;
   logic signed [2*whf_pkg::WEIGHT_W-1:0] wsq_full;
   logic [whf_pkg::CNT_W-1:0]           used_m1;
   logic [whf_pkg::HITS_W-1:0]          idx_raw, idx_clamp;

   logic [whf_pkg::BIN_AW-1:0]          ram_rd_addr;
   logic [whf_pkg::ENTRY_W-1:0]         ram_rd_data, ram_wr_data;
   logic                                ram_wr_en;

   logic signed [whf_pkg::WSUM_W-1:0]   cur_wsum;
   logic [whf_pkg::SSUM_W-1:0]          cur_ssum;
   logic [whf_pkg::HITS_W-1:0]          cur_hits;
   logic                                saturated;

   assign req_take    = req_bus.valid && req_bus.ready;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign finish      = (state_ff == ST_MOD) && out_free;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff     <= '0;
         x_max_ff     <= {1'b0, {(whf_pkg::SAMPLE_W-1){1'b1}}};
         scale_ff     <= whf_pkg::SCALE_W'(1);
         bin_count_ff <= whf_pkg::CNT_W'(whf_pkg::MAX_BINS);
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            whf_pkg::REG_X_MIN:     x_min_ff     <= csr_bus.data[whf_pkg::SAMPLE_W-1:0];
            whf_pkg::REG_X_MAX:     x_max_ff     <= csr_bus.data[whf_pkg::SAMPLE_W-1:0];
            whf_pkg::REG_BIN_SCALE: scale_ff     <= csr_bus.data[whf_pkg::SCALE_W-1:0];
            whf_pkg::REG_BIN_COUNT: bin_count_ff <= csr_bus.data[whf_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_MUL;
         ST_MUL:  state_in = ST_IDX;
         ST_IDX:  state_in = ST_MOD;
         ST_MOD:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture: offset from the lower edge and range check
   always_comb begin
      diff      = {req_bus.sample[whf_pkg::SAMPLE_W-1], req_bus.sample}
                - {x_min_ff[whf_pkg::SAMPLE_W-1], x_min_ff};
      offset_in = diff[whf_pkg::SAMPLE_W-1:0];
      oor_in    = (req_bus.sample < x_min_ff) || (req_bus.sample > x_max_ff);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff     <= req_bus.kind;
         oor_ff      <= oor_in;
         offset_ff   <= offset_in;
         weight_ff   <= req_bus.weight;
         read_bin_ff <= req_bus.read_bin;
      end
   end

   // multiply: scaled offset and squared weight
   always_comb begin
      prod_in   = {{whf_pkg::SCALE_W{1'b0}}, offset_ff}
                * {{whf_pkg::SAMPLE_W{1'b0}}, scale_ff};
      wsq_full  = weight_ff * weight_ff;
      square_in = wsq_full[whf_pkg::SQUARE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff   <= prod_in;
         square_ff <= square_in;
      end
   end

   // index: clamp to the last bin in use, or take the read index
   always_comb begin
      if (bin_count_ff == '0) begin
         used_m1 = '0;
      end else if (bin_count_ff > whf_pkg::CNT_W'(whf_pkg::MAX_BINS)) begin
         used_m1 = whf_pkg::CNT_W'(whf_pkg::MAX_BINS - 1);
      end else begin
         used_m1 = bin_count_ff - whf_pkg::CNT_W'(1);
      end
      idx_raw = prod_ff[whf_pkg::PROD_W-1:whf_pkg::PROD_W-whf_pkg::HITS_W];
      if (idx_raw > whf_pkg::HITS_W'(used_m1)) begin
         idx_clamp = whf_pkg::HITS_W'(used_m1);
      end else begin
         idx_clamp = idx_raw;
      end
      if (kind_ff == whf_pkg::KIND_READ) begin
         idx_in = whf_pkg::BIN_AW'(read_bin_ff);
      end else begin
         idx_in = idx_clamp[whf_pkg::BIN_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDX) begin
         idx_ff <= idx_in;
      end
   end

   // hold the read address while the update waits for the response register
   assign ram_rd_addr = (state_ff == ST_IDX) ? idx_in : idx_ff;

   whf_ram #(
      .WIDTH (whf_pkg::ENTRY_W),
      .DEPTH (whf_pkg::MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // update: a bin never written reads as zero
   always_comb begin
      if (valid_ff[idx_ff]) begin
         {cur_wsum, cur_ssum, cur_hits} = ram_rd_data;
      end else begin
         cur_wsum = '0;
         cur_ssum = '0;
         cur_hits = '0;
      end
      saturated = (cur_hits == whf_pkg::HITS_FULL);

      ram_wr_en   = finish && (kind_ff == whf_pkg::KIND_FILL) && !oor_ff && !saturated;
      ram_wr_data = {cur_wsum + whf_pkg::WSUM_W'(weight_ff),
                     cur_ssum + whf_pkg::SSUM_W'(square_ff),
                     cur_hits + whf_pkg::HITS_W'(1)};

      rsp_wsum_in = '0;
      rsp_ssum_in = '0;
      rsp_hits_in = '0;
      rsp_bin_in  = whf_pkg::BINF_W'(idx_ff);
      if (kind_ff == whf_pkg::KIND_READ) begin
         rsp_status_in = whf_pkg::STATUS_READ_DATA;
         rsp_wsum_in   = cur_wsum;
         rsp_ssum_in   = cur_ssum;
         rsp_hits_in   = cur_hits;
      end else if (oor_ff) begin
         rsp_status_in = whf_pkg::STATUS_OUT_RANGE;
         rsp_bin_in    = '0;
      end else if (saturated) begin
         rsp_status_in = whf_pkg::STATUS_SATURATED;
      end else begin
         rsp_status_in = whf_pkg::STATUS_FILLED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_wr_en) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_bin_ff    <= rsp_bin_in;
         rsp_wsum_ff   <= rsp_wsum_in;
         rsp_ssum_ff   <= rsp_ssum_in;
         rsp_hits_ff   <= rsp_hits_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.bin        = rsp_bin_ff;
   assign rsp_bus.weight_sum = rsp_wsum_ff;
   assign rsp_bus.square_sum = rsp_ssum_ff;
   assign rsp_bus.hit_count  = rsp_hits_ff;

`ifndef SYNTHESIS
   a_take_starts_item: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_MUL)
      else $error("request taken without starting the sequencer");

   a_finish_posts_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("update step did not post a response");

   a_write_marks_bin: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> valid_ff[$past(idx_ff)])
      else $error("written bin not marked valid");

   a_no_write_saturated: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> cur_hits != whf_pkg::HITS_FULL)
      else $error("fill written into a saturated bin");
`endif

endmodule

### rtl/core/whf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module whf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sv/weighted_histogram_fill_unit_tb.sv
// Self-checking testbench for the weighted histogram fill unit.
`timescale 1ns / 1ps

module weighted_histogram_fill_unit_tb;

   localparam int RUN_LIMIT = 400000;
   localparam int IDLE_PCT  = 15;

   typedef struct packed {
      whf_pkg::status_type                 status;
      logic [whf_pkg::BINF_W-1:0]          bin;
      logic signed [whf_pkg::WSUM_W-1:0]   weight_sum;
      logic [whf_pkg::SSUM_W-1:0]          square_sum;
      logic [whf_pkg::HITS_W-1:0]          hit_count;
   } bin_report_type;

   logic clock;
   logic reset;

   whf_req_if req_bus ();
   whf_rsp_if rsp_bus ();
   whf_csr_if csr_bus ();

   weighted_histogram_fill_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Histogram contents and settings as the block should hold them
   logic signed [whf_pkg::WSUM_W-1:0]   bin_wsum [whf_pkg::MAX_BINS];
   logic [whf_pkg::SSUM_W-1:0]          bin_ssum [whf_pkg::MAX_BINS];
   logic [whf_pkg::HITS_W-1:0]          bin_hits [whf_pkg::MAX_BINS];
   logic signed [whf_pkg::SAMPLE_W-1:0] range_lo;
   logic signed [whf_pkg::SAMPLE_W-1:0] range_hi;
   logic [whf_pkg::SCALE_W-1:0]         scale_now;
   logic [whf_pkg::CNT_W-1:0]           count_now;

   bin_report_type awaited_reports[$];

   int  failures;
   int  cycle_count;
   int  stall_cycles;
   logic calm;
   int  fills_binned, fills_outside, reads_done, settings_used;

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------- predictor
   function automatic bin_report_type predict_bin(
         input logic kind,
         input logic signed [whf_pkg::SAMPLE_W-1:0] sample,
         input logic signed [whf_pkg::WEIGHT_W-1:0] weight,
         input logic [whf_pkg::BINF_W-1:0] read_bin);
      bin_report_type              r;
      logic [whf_pkg::SAMPLE_W:0]  offset;
      logic [whf_pkg::PROD_W-1:0]  product;
      logic [31:0]                 square;
      int                          used;
      int                          idx;
      r = '0;
      if (kind == whf_pkg::KIND_READ) begin
         r.status     = whf_pkg::STATUS_READ_DATA;
         r.bin        = read_bin;
         r.weight_sum = bin_wsum[read_bin];
         r.square_sum = bin_ssum[read_bin];
         r.hit_count  = bin_hits[read_bin];
         return r;
      end
      if (sample < range_lo || sample > range_hi) begin
         r.status = whf_pkg::STATUS_OUT_RANGE;
         return r;
      end
      used = int'(count_now);
      if (used < 1) used = 1;
      if (used > whf_pkg::MAX_BINS) used = whf_pkg::MAX_BINS;
      offset  = {sample[whf_pkg::SAMPLE_W-1], sample}
              - {range_lo[whf_pkg::SAMPLE_W-1], range_lo};
      product = whf_pkg::PROD_W'(offset[whf_pkg::SAMPLE_W-1:0])
              * whf_pkg::PROD_W'(scale_now);
      if (product[whf_pkg::PROD_W-1:whf_pkg::SCALE_W] > used - 1)
         idx = used - 1;
      else
         idx = int'(product[whf_pkg::PROD_W-1:whf_pkg::SCALE_W]);
      r.bin = idx[whf_pkg::BINF_W-1:0];
      if (bin_hits[idx] == whf_pkg::HITS_FULL) begin
         r.status = whf_pkg::STATUS_SATURATED;
         return r;
      end
      square        = weight * weight;
      bin_wsum[idx] = bin_wsum[idx] + weight;
      bin_ssum[idx] = bin_ssum[idx] + whf_pkg::SSUM_W'(square);
      bin_hits[idx] = bin_hits[idx] + 1'b1;
      r.status      = whf_pkg::STATUS_FILLED;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_item(input logic kind,
                            input logic signed [whf_pkg::SAMPLE_W-1:0] sample,
                            input logic signed [whf_pkg::WEIGHT_W-1:0] weight,
                            input logic [whf_pkg::BINF_W-1:0] read_bin);
      bin_report_type want;
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.kind     = kind;
      req_bus.sample   = sample;
      req_bus.weight   = weight;
      req_bus.read_bin = read_bin;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      want = predict_bin(kind, sample, weight, read_bin);
      awaited_reports.push_back(want);
      case (want.status)
         whf_pkg::STATUS_READ_DATA: reads_done++;
         whf_pkg::STATUS_OUT_RANGE: fills_outside++;
         default:                   fills_binned++;
      endcase
   endtask

   task automatic fill(input int sample, input int weight);
      send_item(whf_pkg::KIND_FILL, whf_pkg::SAMPLE_W'(sample),
                whf_pkg::WEIGHT_W'(weight), '0);
   endtask

   task automatic read_back(input int bin);
      send_item(whf_pkg::KIND_READ, whf_pkg::SAMPLE_W'($urandom),
                whf_pkg::WEIGHT_W'($urandom), whf_pkg::BINF_W'(bin));
   endtask

   // Hold the sender until every response is in, then let the pipeline settle
   task automatic drain;
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input logic [whf_pkg::CSR_IDX_W-1:0] index,
                                 input logic [whf_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = data;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      case (index)
         whf_pkg::REG_X_MIN:     range_lo  = data;
         whf_pkg::REG_X_MAX:     range_hi  = data;
         whf_pkg::REG_BIN_SCALE: scale_now = data;
         whf_pkg::REG_BIN_COUNT: count_now = data[whf_pkg::CNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_histogram(input int lo, input int hi, input int scale, input int count);
      drain();
      write_register(whf_pkg::REG_X_MIN, whf_pkg::CSR_DATA_W'(lo));
      write_register(whf_pkg::REG_X_MAX, whf_pkg::CSR_DATA_W'(hi));
      write_register(whf_pkg::REG_BIN_SCALE, whf_pkg::CSR_DATA_W'(scale));
      write_register(whf_pkg::REG_BIN_COUNT, whf_pkg::CSR_DATA_W'(count));
      settings_used++;
   endtask

   // Spread the chosen range over the chosen bins, with a little slop
   task automatic set_random_histogram;
      int     lo, hi, count;
      longint scale;
      lo    = int'($urandom_range(0, 12000000)) - 8388608;
      hi    = lo + int'($urandom_range(1, 8388607 - lo));
      count = $urandom_range(1, whf_pkg::MAX_BINS);
      scale = ((longint'(count) << 24) / longint'(hi - lo + 1)) + $urandom_range(0, 3);
      if (scale > 16777215) scale = 16777215;
      set_histogram(lo, hi, int'(scale), count);
   endtask

   function automatic int pick_sample;
      int roll, lo, hi;
      roll = $urandom_range(0, 99);
      lo   = int'(range_lo);
      hi   = int'(range_hi);
      if (lo <= hi && roll < 80)
         return lo + int'($urandom_range(0, hi - lo));
      if (roll < 90) begin
         case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1;
            default: return hi + 1;
         endcase
      end
      return int'($urandom_range(0, 16777215));
   endfunction

   task automatic run_random_items(input int n);
      int used, weight;
      used = (count_now < 1) ? 1 :
             (count_now > whf_pkg::MAX_BINS) ? whf_pkg::MAX_BINS : int'(count_now);
      repeat (n) begin
         if ($urandom_range(0, 99) < 25) begin
            if ($urandom_range(0, 9) < 7)
               read_back($urandom_range(0, used - 1));
            else
               read_back($urandom_range(0, whf_pkg::MAX_BINS - 1));
         end else begin
            case ($urandom_range(0, 19))
               0:       weight = 32767;
               1:       weight = -32768;
               2:       weight = 0;
               default: weight = int'($urandom_range(0, 65535));
            endcase
            fill(pick_sample(), weight);
         end
      end
   endtask

   // ---------------------------------------------------------------- response side
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            stall_cycles  = stall_cycles - 1;
         end else if (calm) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : response_check
      bin_report_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_reports.size() == 0) begin
            $error("response with nothing awaited: status %0d bin %0d",
                   rsp_bus.status, rsp_bus.bin);
            failures++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_bus.status);
               failures++;
            end
            if (rsp_bus.bin !== want.bin) begin
               $error("bin expected %0d got %0d", want.bin, rsp_bus.bin);
               failures++;
            end
            if (rsp_bus.weight_sum !== want.weight_sum) begin
               $error("weight_sum expected %0d got %0d", want.weight_sum, rsp_bus.weight_sum);
               failures++;
            end
            if (rsp_bus.square_sum !== want.square_sum) begin
               $error("square_sum expected %0d got %0d", want.square_sum, rsp_bus.square_sum);
               failures++;
            end
            if (rsp_bus.hit_count !== want.hit_count) begin
               $error("hit_count expected %0d got %0d", want.hit_count, rsp_bus.hit_count);
               failures++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, awaited_reports.size());
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- tests
   task automatic test_cleared_after_reset;
      read_back(0);
      read_back(128);
      read_back(whf_pkg::MAX_BINS - 1);
   endtask

   // Reset settings: scale 1 keeps every in-range sample in bin 0; negative samples fall below the range
   task automatic test_default_range;
      fill(0, 32767);
      fill(8388607, -32768);
      fill(-1, 5);
      fill(-8388608, 7);
      read_back(0);
   endtask

   task automatic test_full_range_bins;
      set_histogram(-8388608, 8388607, 256, 256);
      fill(-8388608, 1);
      fill(8388607, -1);
      fill(0, 300);
      read_back(255);
      read_back(128);
   endtask

   task automatic test_upper_edge_clamp;
      set_histogram(0, 1000, 16777215, 10);
      fill(1000, 100);
      fill(0, -100);
      fill(1001, 3);
      read_back(9);
   endtask

   task automatic test_inverted_range;
      set_histogram(100, -100, 1000, 16);
      fill(0, 11);
      fill(100, 12);
      fill(-100, 13);
   endtask

   task automatic test_zero_scale;
      set_histogram(-100, 100, 0, 64);
      fill(100, 21);
      fill(-100, 22);
      read_back(0);
   endtask

   // Count 0 behaves as one bin, counts above the store as the full store;
   // reads beyond the bins in use still return what is stored
   task automatic test_bin_count_limits;
      set_histogram(-100, 100, 16777215, 0);
      fill(50, 31);
      read_back(0);
      set_histogram(-100, 100, 16777215, 300);
      fill(100, 32);
      fill(-100, 33);
      set_histogram(-100, 100, 16777215, 10);
      read_back(199);
   endtask

   task automatic test_random_fills;
      set_histogram(-8388608, 8388607, 256, 256);
      run_random_items(250);
      set_random_histogram();
      run_random_items(250);
      set_random_histogram();
      calm = 1'b1;
      run_random_items(200);
      calm = 1'b0;
   endtask

   // Stop taking responses while requests keep coming so the input backs up
   task automatic test_output_backpressure;
      set_random_histogram();
      stall_cycles = 400;
      run_random_items(200);
   endtask

   task automatic test_sender_pause;
      set_histogram(-8388608, 8388607, 16777215, 256);
      run_random_items(125);
      drain();
      set_random_histogram();
      run_random_items(125);
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.kind     = whf_pkg::KIND_FILL;
      req_bus.sample   = '0;
      req_bus.weight   = '0;
      req_bus.read_bin = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = whf_pkg::REG_X_MIN;
      csr_bus.data     = '0;
      failures         = 0;
      cycle_count      = 0;
      stall_cycles     = 0;
      calm             = 1'b0;
      fills_binned     = 0;
      fills_outside    = 0;
      reads_done       = 0;
      settings_used    = 1;
      range_lo         = '0;
      range_hi         = 24'sd8388607;
      scale_now        = 24'd1;
      count_now        = 9'd256;
      for (int i = 0; i < whf_pkg::MAX_BINS; i++) begin
         bin_wsum[i] = '0;
         bin_ssum[i] = '0;
         bin_hits[i] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_after_reset();
      test_default_range();
      test_full_range_bins();
      test_upper_edge_clamp();
      test_inverted_range();
      test_zero_scale();
      test_bin_count_limits();
      test_random_fills();
      test_output_backpressure();
      test_sender_pause();

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d binned fills, %0d out-of-range fills, %0d bin reads",
               fills_binned, fills_outside, reads_done);
      $display("under %0d histogram settings in %0d cycles", settings_used, cycle_count);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
